/* sv/mesh_vertex_adjacency_builder_unit_macros.svh */
// assertion macros for the adjacency builder
`ifndef MESH_VERTEX_ADJACENCY_BUILDER_UNIT_MACROS_SVH
`define MESH_VERTEX_ADJACENCY_BUILDER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MVAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MVAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MVAB_ASSERT_IMP(lbl, ante, cons)
`define MVAB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/mvab_pkg.sv */
package mvab_pkg;
  localparam int VTX_W  = 11;
  localparam int DEG_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  localparam logic [VTX_W-1:0] VCOUNT_RESET = 11'd1024;
endpackage

/* sv/mvab_ram.sv */
module mvab_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 6,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* sv/mesh_vertex_adjacency_builder_unit.sv */
// Vertex adjacency builder: keeps a sorted, duplicate-free neighbor list per vertex.
// Command channel: an item is taken at a clock edge with start high and busy low.
// command 0 adds a face (edges taken in ascending order go into both lists),
// 1 streams the neighbors of first_vertex, 2 clears every list.
// Results appear on neighbor/degree/status/last for one cycle each, marked by done;
// the receiver cannot stall, so every result is taken the cycle it is shown.
// The write channel cfg_valid/cfg_ready/cfg_data sets vertex_count (always ready).
// Sequencing, set by the one-read-per-cycle list memory and a read-then-use sequencer:
//   face: per accepted edge insert, read the count, scan the list, shift larger
//         entries up and write; up to six inserts, then collect overflow marks
//   read: read the count, then one list read per neighbor, each followed by its result
//   clear: sweep every entry of the count memory, then one result
//   bad index or unused command: result the cycle after acceptance
// After reset the block sweeps the count memory with busy high; configuration writes
// are taken during that sweep.
// Only one memory access per entry is in flight at a time, so no forwarding is needed.
`include "mesh_vertex_adjacency_builder_unit_macros.svh"
module mesh_vertex_adjacency_builder_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [mvab_pkg::VTX_W-1:0]    first_vertex,
  input  logic [mvab_pkg::VTX_W-1:0]    second_vertex,
  input  logic [mvab_pkg::VTX_W-1:0]    third_vertex,
  output logic                          done,
  output logic [mvab_pkg::VTX_W-1:0]    neighbor,
  output logic [mvab_pkg::DEG_W-1:0]    degree,
  output logic [mvab_pkg::STAT_W-1:0]   status,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvab_pkg::VTX_W-1:0]    cfg_data
);
  import mvab_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = $clog2(MAX_DEGREE);
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int SAW = VW + DW;
  localparam int ST_DEPTH = MAX_VERTICES * (2 ** DW);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_EDGE  = 5'd2;
  localparam logic [4:0] S_MRD   = 5'd3;
  localparam logic [4:0] S_MCHK  = 5'd4;
  localparam logic [4:0] S_SRD   = 5'd5;
  localparam logic [4:0] S_SCHK  = 5'd6;
  localparam logic [4:0] S_PLACE = 5'd7;
  localparam logic [4:0] S_SHRD  = 5'd8;
  localparam logic [4:0] S_SHWR  = 5'd9;
  localparam logic [4:0] S_PUT   = 5'd10;
  localparam logic [4:0] S_ORD   = 5'd11;
  localparam logic [4:0] S_OCHK  = 5'd12;
  localparam logic [4:0] S_RMRD  = 5'd13;
  localparam logic [4:0] S_RMCHK = 5'd14;
  localparam logic [4:0] S_RRD   = 5'd15;
  localparam logic [4:0] S_REMIT = 5'd16;

  logic [4:0]       state;
  logic [VW-1:0]    clr_cnt;
  logic             clr_cmd;
  logic [VTX_W-1:0] vertex_count;
  logic [VTX_W-1:0] va, vb, vc;
  logic [2:0]       ins;
  logic [1:0]       oi;
  logic [VW-1:0]    cur_slot;
  logic [VTX_W-1:0] cur_val;
  logic [CW-1:0]    n;
  logic             ovf;
  logic             ovf_acc;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    k;

  logic             meta_rd_en, meta_wr_en;
  logic [VW-1:0]    meta_rd_addr, meta_wr_addr;
  logic [CW:0]      meta_wr_data, meta_rd_data;
  logic             st_rd_en, st_wr_en;
  logic [SAW-1:0]   st_rd_addr, st_wr_addr;
  logic [VTX_W-1:0] st_wr_data, st_rd_data;

  logic             a_ok, b_ok, c_ok;
  logic [VTX_W-1:0] edge_p, edge_q;
  logic [VW-1:0]    corner_slot;
  logic [CW-1:0]    km1;
  logic             full;

  function automatic logic index_ok(input logic [VTX_W-1:0] v,
                                    input logic [VTX_W-1:0] lim);
    index_ok = (v != '0) && (v <= lim) && (32'(v) <= MAX_VERTICES);
  endfunction

  function automatic logic [VW-1:0] to_slot(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] s;
    s = v - 1'b1;
    to_slot = VW'(s);
  endfunction

  assign a_ok = index_ok(first_vertex, vertex_count);
  assign b_ok = index_ok(second_vertex, vertex_count);
  assign c_ok = index_ok(third_vertex, vertex_count);
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign km1 = CW'(k - 1'b1);
  assign full = (n >= CW'(MAX_DEGREE));

  always_comb begin
    case (ins[2:1])
      2'd0:    begin edge_p = va; edge_q = vb; end
      2'd1:    begin edge_p = vb; edge_q = vc; end
      default: begin edge_p = vc; edge_q = va; end
    endcase
    case (oi)
      2'd0:    corner_slot = to_slot(va);
      2'd1:    corner_slot = to_slot(vb);
      default: corner_slot = to_slot(vc);
    endcase
  end

  always_comb begin
    meta_rd_en   = (state == S_MRD) || (state == S_ORD) || (state == S_RMRD);
    meta_rd_addr = (state == S_ORD) ? corner_slot : cur_slot;
    meta_wr_en   = (state == S_CLR) || (state == S_PUT) || ((state == S_PLACE) && full);
    meta_wr_addr = (state == S_CLR) ? clr_cnt : cur_slot;
    if (state == S_CLR) begin
      meta_wr_data = '0;
    end else if (state == S_PUT) begin
      meta_wr_data = {ovf, CW'(n + 1'b1)};
    end else begin
      meta_wr_data = {1'b1, n};
    end
    st_rd_en   = (state == S_SRD) || (state == S_SHRD) || (state == S_RRD);
    st_rd_addr = {cur_slot, (state == S_SHRD) ? km1[DW-1:0] : pos[DW-1:0]};
    st_wr_en   = (state == S_SHWR) || (state == S_PUT);
    st_wr_addr = {cur_slot, (state == S_SHWR) ? k[DW-1:0] : pos[DW-1:0]};
    st_wr_data = (state == S_SHWR) ? st_rd_data : cur_val;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state        <= S_CLR;
      clr_cnt      <= '0;
      clr_cmd      <= 1'b0;
      vertex_count <= VCOUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            va <= first_vertex;
            vb <= second_vertex;
            vc <= third_vertex;
            neighbor <= '0;
            degree   <= '0;
            status   <= ST_OK;
            last     <= 1'b1;
            unique case (command)
              CMD_ADD: begin
                if (a_ok && b_ok && c_ok) begin
                  ins     <= '0;
                  ovf_acc <= 1'b0;
                  state   <= S_EDGE;
                end else begin
                  status <= ST_RANGE;
                  done   <= 1'b1;
                end
              end
              CMD_READ: begin
                if (a_ok) begin
                  cur_slot <= to_slot(first_vertex);
                  state    <= S_RMRD;
                end else begin
                  status <= ST_RANGE;
                  done   <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                clr_cnt <= '0;
                clr_cmd <= 1'b1;
                state   <= S_CLR;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VW'(MAX_VERTICES - 1)) begin
            if (clr_cmd) begin
              neighbor <= '0;
              degree   <= '0;
              status   <= ST_OK;
              last     <= 1'b1;
              done     <= 1'b1;
            end
            clr_cmd <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_EDGE: begin
          if (edge_p < edge_q) begin
            cur_slot <= to_slot(ins[0] ? edge_q : edge_p);
            cur_val  <= ins[0] ? edge_p : edge_q;
            state    <= S_MRD;
          end else if (ins == 3'd5) begin
            oi    <= '0;
            state <= S_ORD;
          end else begin
            ins <= ins + 1'b1;
          end
        end
        S_MRD: begin
          state <= S_MCHK;
        end
        S_MCHK: begin
          n   <= meta_rd_data[CW-1:0];
          ovf <= meta_rd_data[CW];
          pos <= '0;
          k   <= '0;
          state <= (meta_rd_data[CW-1:0] == '0) ? S_PLACE : S_SRD;
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (st_rd_data == cur_val) begin
            // already present, nothing to do
            if (ins == 3'd5) begin
              oi    <= '0;
              state <= S_ORD;
            end else begin
              ins   <= ins + 1'b1;
              state <= S_EDGE;
            end
          end else if (st_rd_data > cur_val) begin
            k     <= n;
            state <= S_PLACE;
          end else if (CW'(pos + 1'b1) == n) begin
            pos   <= n;
            k     <= n;
            state <= S_PLACE;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_SRD;
          end
        end
        S_PLACE: begin
          if (full) begin
            // insert dropped, overflow mark written this cycle
            if (ins == 3'd5) begin
              oi    <= '0;
              state <= S_ORD;
            end else begin
              ins   <= ins + 1'b1;
              state <= S_EDGE;
            end
          end else if (k > pos) begin
            state <= S_SHRD;
          end else begin
            state <= S_PUT;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          k     <= km1;
          state <= (km1 == pos) ? S_PUT : S_SHRD;
        end
        S_PUT: begin
          if (ins == 3'd5) begin
            oi    <= '0;
            state <= S_ORD;
          end else begin
            ins   <= ins + 1'b1;
            state <= S_EDGE;
          end
        end
        S_ORD: begin
          state <= S_OCHK;
        end
        S_OCHK: begin
          ovf_acc <= ovf_acc | meta_rd_data[CW];
          if (oi == 2'd2) begin
            neighbor <= '0;
            degree   <= '0;
            status   <= (ovf_acc | meta_rd_data[CW]) ? ST_OVF : ST_OK;
            last     <= 1'b1;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            oi    <= oi + 1'b1;
            state <= S_ORD;
          end
        end
        S_RMRD: begin
          state <= S_RMCHK;
        end
        S_RMCHK: begin
          n   <= meta_rd_data[CW-1:0];
          ovf <= meta_rd_data[CW];
          pos <= '0;
          if (meta_rd_data[CW-1:0] == '0) begin
            neighbor <= '0;
            degree   <= '0;
            status   <= meta_rd_data[CW] ? ST_OVF : ST_OK;
            last     <= 1'b1;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_RRD;
          end
        end
        S_RRD: begin
          state <= S_REMIT;
        end
        S_REMIT: begin
          neighbor <= st_rd_data;
          degree   <= DEG_W'(n);
          status   <= ovf ? ST_OVF : ST_OK;
          last     <= (CW'(pos + 1'b1) == n);
          done     <= 1'b1;
          if (CW'(pos + 1'b1) == n) begin
            state <= S_IDLE;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_RRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mvab_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(CW + 1),
    .AW   (VW)
  ) u_meta (
    .clk    (clk),
    .wr_en  (meta_wr_en),
    .wr_addr(meta_wr_addr),
    .wr_data(meta_wr_data),
    .rd_en  (meta_rd_en),
    .rd_addr(meta_rd_addr),
    .rd_data(meta_rd_data)
  );

  mvab_ram #(
    .DEPTH(ST_DEPTH),
    .WIDTH(VTX_W),
    .AW   (SAW)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_data(st_wr_data),
    .rd_en  (st_rd_en),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

  // list writes stay inside the current count
  `MVAB_ASSERT_IMP(a_wr_in_list, st_wr_en, (k <= n) && (pos <= n) && !full)
  // streamed neighbors never come back to back
  `MVAB_ASSERT_NXT(a_stream_gap, done && !last, !done)
  // a non-final result only comes from a read of a non-empty list
  `MVAB_ASSERT_IMP(a_mid_degree, done && !last, (degree != '0) && (status != ST_RANGE))
endmodule
